>>> hw/rtl/ofai_pkg.sv
// shared codes and reset values for the alpha-investing fdr block
// no dependencies
`default_nettype none
package ofai_pkg;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_TEST    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ACK  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] CFG_ALPHA = 2'd0;
    localparam logic [1:0] CFG_W0    = 2'd1;

    localparam logic [31:0] ALPHA_RST = 32'd214748365;
    localparam logic [31:0] W0_RST    = 32'd107374182;

    // raw level saturates at 2^60-1
    localparam int RAW_W = 60;

endpackage
`default_nettype wire

>>> hw/rtl/ofai_gamma_mem.sv
// gamma table memory with a loading sweep of the default sequence after reset
// depends on nothing but its parameters
`default_nettype none
module ofai_gamma_mem #(
    parameter int DEPTH     = 1024,
    parameter int FRAC_BITS = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [31:0]              o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [31:0]              i_wr_data,
    output logic                          o_init_done
);
    localparam int AW = $clog2(DEPTH);

    typedef logic [31:0] t_rom [DEPTH];

    // floor(A / k^1.6) found as the largest g with g^5 * k^8 <= A^5
    function automatic t_rom build_rom();
        t_rom          rom;
        logic [127:0]  rr;
        logic [127:0]  a;
        logic [319:0]  target;
        logic [319:0]  kp;
        logic [319:0]  tr;
        logic [63:0]   prev;
        logic [63:0]   lo;
        logic [63:0]   hi;
        logic [63:0]   mid;
        rr = 128'd4374901658;
        a  = '0;
        for (int b = 0; b < FRAC_BITS; b++) begin
            rr = rr << 1;
            a  = a << 1;
            if (rr >= 128'd10000000000) begin
                rr   = rr - 128'd10000000000;
                a[0] = 1'b1;
            end
        end
        target = 320'd1;
        for (int n = 0; n < 5; n++) target = target * 320'(a);
        prev = a[63:0];
        for (int k = 1; k <= DEPTH; k++) begin
            kp = 320'd1;
            for (int n = 0; n < 8; n++) kp = kp * 320'(k);
            lo = '0;
            hi = prev;
            while (lo < hi) begin
                mid = lo + (hi - lo + 64'd1) / 2;
                tr  = kp;
                for (int n = 0; n < 5; n++) tr = tr * 320'(mid);
                if (tr <= target) lo = mid;
                else              hi = mid - 64'd1;
            end
            prev = lo;
            rom[k-1] = (lo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lo[31:0];
        end
        return rom;
    endfunction

    localparam t_rom GAMMA_ROM = build_rom();

    logic [31:0]   r_mem [DEPTH];
    logic [AW-1:0] r_init_cnt;
    logic          r_init_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_cnt  <= '0;
            r_init_busy <= 1'b1;
        end else if (r_init_busy) begin
            r_init_cnt <= r_init_cnt + AW'(1);
            if (r_init_cnt == AW'(DEPTH - 1)) r_init_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_init_busy) begin
            r_mem[r_init_cnt] <= GAMMA_ROM[r_init_cnt];
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

    assign o_init_done = !r_init_busy;

endmodule
`default_nettype wire

>>> hw/rtl/ofai_div.sv
// bit-serial restoring divide: floor(raw * 2^F / (2^F + raw)), one bit per cycle
// uses ofai_pkg for the raw width
`default_nettype none
module ofai_div #(
    parameter int FRAC_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ofai_pkg::RAW_W-1:0]  i_raw,
    output logic                             o_done,
    output logic      [FRAC_BITS-1:0]        o_quot
);
    localparam int CW = $clog2(FRAC_BITS + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_rem;
    logic [63:0]   r_den;
    logic [63:0]   n_rem2;
    logic          n_bit;

    assign n_rem2 = r_rem << 1;
    assign n_bit  = (n_rem2 >= r_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= 64'(i_raw);
            r_den  <= (64'd1 << FRAC_BITS) + 64'(i_raw);
            o_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_bit ? (n_rem2 - r_den) : n_rem2;
            o_quot <= {o_quot[FRAC_BITS-2:0], n_bit};
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/online_fdr_alpha_investing_top.sv
// alpha-investing online fdr test: sequencer, rejection-time memory, registers
// a test with K earlier rejections walks serially over the rejection times and gamma
// reads, then runs the bit-serial divide
// table writes, restarts and over-capacity tests: result in the cycle after transfer
// one item at a time; after reset the gamma table is loaded with its default sequence,
// during which no item is taken; configuration writes are taken at all times
// depends on ofai_pkg, ofai_gamma_mem, ofai_div
`default_nettype none
module online_fdr_alpha_investing_top #(
    parameter int MAX_TESTS = 1024,
    parameter int FRAC_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [9:0]  i_gamma_index,
    input  wire logic [31:0] i_gamma_value,
    input  wire logic [31:0] i_p_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic      [9:0]  o_test_index,
    output logic      [31:0] o_level,
    output logic             o_rejected,
    output logic      [1:0]  o_status,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(MAX_TESTS);
    localparam int CW = $clog2(MAX_TESTS + 1);
    localparam int RW = ofai_pkg::RAW_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_GWAIT = 3'd1;
    localparam logic [2:0] S_ACC   = 3'd2;
    localparam logic [2:0] S_TWAIT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    r_state;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_j;
    logic [RW-1:0] r_raw;
    logic [63:0]   r_prod;
    logic [31:0]   r_p;
    logic [31:0]   r_alpha;
    logic [31:0]   r_w0;
    logic [31:0]   r_lvl;
    logic          r_rej;

    logic [AW-1:0] r_times_mem [MAX_TESTS];
    logic [AW-1:0] r_times_rd;

    logic [AW-1:0]        g_rd_addr;
    logic [31:0]          g_rd_data;
    logic                 g_wr_en;
    logic                 init_done;
    logic [AW-1:0]        times_rd_addr;
    logic                 div_start;
    logic                 div_done;
    logic [FRAC_BITS-1:0] div_quot;

    logic          accept;
    logic          slot_free;
    logic          full;
    logic          out_load;
    logic [31:0]   excess;
    logic [31:0]   coef;
    logic [63:0]   sum;
    logic [RW-1:0] n_raw;
    logic [63:0]   quot_ext;
    logic [CW-1:0] n_gaddr;

    assign slot_free  = !o_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && init_done && slot_free;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_i == CW'(MAX_TESTS));
    assign o_cfg_ready = 1'b1;

    // a result is loaded at transfer for every non-test item and every over-capacity test, and for every finished test
    assign out_load = ((r_state == S_IDLE) && accept
                       && !((i_op == ofai_pkg::OP_TEST) && !full))
                      || ((r_state == S_OUT) && slot_free);

    assign excess = (r_alpha > r_w0) ? (r_alpha - r_w0) : 32'd0;
    assign coef   = (r_j == '0) ? r_w0 : ((r_j == CW'(1)) ? excess : r_alpha);
    assign sum    = 64'(r_raw) + (r_prod >> FRAC_BITS);
    assign n_raw  = (sum > 64'({RW{1'b1}})) ? {RW{1'b1}} : sum[RW-1:0];

    // gamma index i - t - (K - j) - 1 for the term of rejection j
    always_comb begin
        if (r_state == S_TWAIT) n_gaddr = r_i - CW'(r_times_rd) - (r_k - r_j) - CW'(1);
        else                    n_gaddr = r_i - r_k;
    end
    assign g_rd_addr = n_gaddr[AW-1:0];
    assign times_rd_addr = r_j[AW-1:0];
    assign g_wr_en   = accept && (i_op == ofai_pkg::OP_WRITE)
                       && (32'(i_gamma_index) < 32'(MAX_TESTS));
    assign div_start = (r_state == S_ACC) && (r_j == r_k);

    assign quot_ext = 64'(div_quot);

    ofai_gamma_mem #(
        .DEPTH     (MAX_TESTS),
        .FRAC_BITS (FRAC_BITS)
    ) u_gamma (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_addr   (g_rd_addr),
        .o_rd_data   (g_rd_data),
        .i_wr_en     (g_wr_en),
        .i_wr_addr   (AW'(i_gamma_index)),
        .i_wr_data   (i_gamma_value),
        .o_init_done (init_done)
    );

    // the divide starts on the sum that includes the last term
    ofai_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_raw   (n_raw),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ofai_pkg::ALPHA_RST;
            r_w0    <= ofai_pkg::W0_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ofai_pkg::CFG_ALPHA: r_alpha <= i_cfg_data;
                ofai_pkg::CFG_W0:    r_w0    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // rejection times
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && slot_free && r_rej && (r_k < CW'(MAX_TESTS))) begin
            r_times_mem[r_k[AW-1:0]] <= r_i[AW-1:0];
        end
        r_times_rd <= r_times_mem[times_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_k         <= '0;
            r_j         <= '0;
            o_out_valid <= 1'b0;
        end else begin
            o_out_valid <= out_load || (o_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_op == ofai_pkg::OP_TEST && !full) begin
                            r_j     <= '0;
                            r_state <= S_GWAIT;
                        end else begin
                            if (i_op == ofai_pkg::OP_RESTART) begin
                                r_i <= '0;
                                r_k <= '0;
                            end
                        end
                    end
                end
                S_GWAIT: r_state <= S_ACC;
                S_ACC: begin
                    if (r_j == r_k) begin
                        r_state <= S_DIV;
                    end else begin
                        r_j     <= r_j + CW'(1);
                        r_state <= S_TWAIT;
                    end
                end
                S_TWAIT: r_state <= S_GWAIT;
                S_DIV: begin
                    if (div_done) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (slot_free) begin
                        r_i         <= r_i + CW'(1);
                        if (r_rej && (r_k < CW'(MAX_TESTS))) r_k <= r_k + CW'(1);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_p    <= i_p_value;
            r_raw  <= '0;
            o_test_index <= 10'd0;
            o_level      <= 32'd0;
            o_rejected   <= 1'b0;
            if (i_op == ofai_pkg::OP_TEST && full) o_status <= ofai_pkg::ST_FULL;
            else                                   o_status <= ofai_pkg::ST_ACK;
        end
        if (r_state == S_GWAIT) r_prod <= 64'(coef) * 64'(g_rd_data);
        if (r_state == S_ACC) begin
            r_raw <= n_raw;
        end
        if (r_state == S_DIV && div_done) begin
            r_lvl <= (quot_ext > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot_ext[31:0];
            r_rej <= (64'(r_p) <= quot_ext);
        end
        if (r_state == S_OUT && slot_free) begin
            o_test_index <= 10'(r_i);
            o_level      <= r_lvl;
            o_rejected   <= r_rej;
            o_status     <= ofai_pkg::ST_DONE;
        end
    end

    a_k_le_i: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_k <= r_i)
        else $error("rejection count above test count");
    a_no_item_during_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !init_done |-> !o_in_ready)
        else $error("item taken while gamma table loads");
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divide finished outside divide wait");
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_done) |=> r_state == S_OUT)
        else $error("sequencer missed divide result");

endmodule
`default_nettype wire

>>> test/tb_online_fdr_alpha_investing_top.sv
// testbench for online_fdr_alpha_investing_top: directed and random p-value tests,
// gamma table writes, restarts and register changes, checked against a local predictor
// depends on ofai_pkg and the block's rtl
`default_nettype none
module tb_online_fdr_alpha_investing_top;

    localparam int  TESTS_MAX  = 1024;
    localparam int  WDOG_LIMIT = 20000;
    localparam int  HOLD_LEN   = 400;
    localparam int  RAND_LEN   = 30;
    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [63:0] RAW_SAT = (64'd1 << ofai_pkg::RAW_W) - 64'd1;

    typedef struct {
        bit          is_cfg;
        logic [1:0]  op;
        logic [9:0]  gidx;
        logic [31:0] gval;
        logic [31:0] pval;
        logic [1:0]  cidx;
        logic [31:0] cdata;
        int          send_pct;
        int          recv_pct;
        bit          hold;
    } t_txn;

    typedef struct {
        logic [9:0]  test_index;
        logic [31:0] level;
        logic        rejected;
        logic [1:0]  status;
    } t_verdict;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [9:0]  i_gamma_index;
    logic [31:0] i_gamma_value;
    logic [31:0] i_p_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [9:0]  o_test_index;
    logic [31:0] o_level;
    logic        o_rejected;
    logic [1:0]  o_status;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    online_fdr_alpha_investing_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_op(i_op), .i_gamma_index(i_gamma_index),
        .i_gamma_value(i_gamma_value), .i_p_value(i_p_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_test_index(o_test_index), .o_level(o_level),
        .o_rejected(o_rejected), .o_status(o_status),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [31:0] gamma_tab [TESTS_MAX];
    logic [9:0]  reject_at [TESTS_MAX];
    int          reject_cnt;
    int          test_cnt;
    logic [31:0] alpha_reg;
    logic [31:0] wealth_reg;

    t_txn     pending_q [$];
    t_verdict level_expect_q [$];
    int       recv_pct;
    bit       hold_req;
    int       hold_cnt;
    int       fail_cnt;
    int       quiet_cnt;

    function automatic void queue_item(t_txn t);
        pending_q.insert(pending_q.size(), t);
    endfunction

    function automatic logic [63:0] gamma_at(longint idx);
        if (idx < 0 || idx >= TESTS_MAX) return 64'd0;
        return {32'd0, gamma_tab[idx]};
    endfunction

    function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] g);
        logic [63:0] prod;
        prod = a * g;
        return prod >> 32;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        if (a > RAW_SAT || b > RAW_SAT - a) return RAW_SAT;
        return a + b;
    endfunction

    // floor(A / k^1.6) as the largest g with g^5 * k^8 <= A^5
    task automatic load_default_gamma();
        logic [63:0]  rem, a_fix, prev, lo, hi, mid;
        logic [255:0] target, kpow, trial;
        rem = 64'd4374901658;
        a_fix = 0;
        for (int b = 0; b < 32; b++) begin
            rem = rem << 1;
            a_fix = a_fix << 1;
            if (rem >= 64'd10000000000) begin
                rem = rem - 64'd10000000000;
                a_fix[0] = 1'b1;
            end
        end
        target = 256'd1;
        for (int n = 0; n < 5; n++) target = target * a_fix;
        prev = a_fix;
        for (int k = 1; k <= TESTS_MAX; k++) begin
            kpow = 256'd1;
            for (int n = 0; n < 8; n++) kpow = kpow * k;
            lo = 0;
            hi = prev;
            while (lo < hi) begin
                mid = lo + (hi - lo + 1) / 2;
                trial = kpow;
                for (int n = 0; n < 5; n++) trial = trial * mid;
                if (trial <= target) lo = mid;
                else hi = mid - 1;
            end
            prev = lo;
            gamma_tab[k-1] = (lo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : lo[31:0];
        end
    endtask

    function automatic t_verdict level_predict(t_txn t);
        t_verdict    v;
        logic [63:0] excess, raw, dvs, rem, q;
        longint      i, kk;
        v = '{test_index: '0, level: '0, rejected: 1'b0, status: ofai_pkg::ST_ACK};
        if (t.op == ofai_pkg::OP_WRITE) begin
            gamma_tab[t.gidx] = t.gval;
        end else if (t.op == ofai_pkg::OP_RESTART) begin
            reject_cnt = 0;
            test_cnt = 0;
        end else if (t.op == ofai_pkg::OP_TEST) begin
            i = test_cnt;
            kk = reject_cnt;
            if (test_cnt >= TESTS_MAX || kk > i) begin
                v.status = ofai_pkg::ST_FULL;
                return v;
            end
            excess = (alpha_reg > wealth_reg) ? {32'd0, alpha_reg - wealth_reg} : 64'd0;
            raw = frac_mul({32'd0, wealth_reg}, gamma_at(i - kk));
            for (longint j = 1; j <= kk; j++)
                raw = sat_add(raw, frac_mul((j == 1) ? excess : {32'd0, alpha_reg},
                              gamma_at(i - reject_at[j-1] - (kk - j) - 1)));
            dvs = (64'd1 << 32) + raw;
            rem = raw;
            q = 0;
            for (int b = 0; b < 32; b++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= dvs) begin
                    rem = rem - dvs;
                    q[0] = 1'b1;
                end
            end
            v.test_index = i[9:0];
            v.level = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            v.rejected = ({32'd0, t.pval} <= q);
            v.status = ofai_pkg::ST_DONE;
            if (v.rejected && reject_cnt < TESTS_MAX) begin
                reject_at[reject_cnt] = i[9:0];
                reject_cnt++;
            end
            test_cnt++;
        end
        return v;
    endfunction

    // stimulus builders
    function automatic t_txn mk_item(logic [1:0] op, logic [9:0] gidx, logic [31:0] gval,
                                     logic [31:0] pval, int sp, int rp);
        t_txn t;
        t = '{is_cfg: 0, op: op, gidx: gidx, gval: gval, pval: pval,
              cidx: ofai_pkg::CFG_ALPHA, cdata: 0, send_pct: sp, recv_pct: rp, hold: 0};
        return t;
    endfunction

    function automatic void push_cfg(logic [31:0] alpha, logic [31:0] w0);
        t_txn t;
        t = mk_item(ofai_pkg::OP_TEST, 0, 0, 0, 0, 0);
        t.is_cfg = 1;
        t.cidx = ofai_pkg::CFG_ALPHA;
        t.cdata = alpha;
        queue_item(t);
        t.cidx = ofai_pkg::CFG_W0;
        t.cdata = w0;
        queue_item(t);
    endfunction

    function automatic void push_random(int n, int sp, int rp);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 4)
                queue_item(mk_item(ofai_pkg::OP_RESTART, 10'($urandom), $urandom, $urandom,
                                   sp, rp));
            else if (r < 6)
                queue_item(mk_item(OP_UNUSED, 10'($urandom), $urandom, $urandom, sp, rp));
            else if (r < 22)
                queue_item(mk_item(ofai_pkg::OP_WRITE, 10'($urandom), $urandom, $urandom,
                                   sp, rp));
            else if (r < 30)
                queue_item(mk_item(ofai_pkg::OP_TEST, 10'($urandom), $urandom,
                                   $urandom_range(1 << 20), sp, rp));
            else
                queue_item(mk_item(ofai_pkg::OP_TEST, 10'($urandom), $urandom, $urandom,
                                   sp, rp));
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        t_txn t;
        i_rst_n = 1'b0;
        fail_cnt = 0;
        reject_cnt = 0;
        test_cnt = 0;
        alpha_reg = ofai_pkg::ALPHA_RST;
        wealth_reg = ofai_pkg::W0_RST;
        recv_pct = 0;
        load_default_gamma();

        // directed part at reset settings, then register extremes
        queue_item(mk_item(ofai_pkg::OP_TEST, 10'h3FF, 32'hFFFF_FFFF, 32'd0, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_TEST, 0, 0, 32'hFFFF_FFFF, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_TEST, 0, 0, 32'd1000, 0, 0));
        queue_item(mk_item(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_WRITE, 10'd0, 32'hFFFF_FFFF, 0, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_WRITE, 10'h3FF, 32'd0, 32'hFFFF_FFFF, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_WRITE, 10'd1, 32'h8000_0000, 0, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_RESTART, 0, 0, 0, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_TEST, 0, 0, 32'd0, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_TEST, 0, 0, 32'd0, 0, 0));
        queue_item(mk_item(ofai_pkg::OP_TEST, 0, 0, 32'hFFFF_FFFF, 0, 0));
        push_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(mk_item(ofai_pkg::OP_RESTART, 0, 0, 0, 0, 0));
        for (int k = 0; k < 4; k++)
            queue_item(mk_item(ofai_pkg::OP_TEST, 0, 0, 32'hFFFF_FFFF, 0, 0));
        // wealth above alpha
        push_cfg(32'd100, 32'hFFFF_FFFF);
        queue_item(mk_item(ofai_pkg::OP_RESTART, 0, 0, 0, 0, 0));
        for (int k = 0; k < 3; k++)
            queue_item(mk_item(ofai_pkg::OP_TEST, 0, 0, 32'd0, 0, 0));
        push_cfg(32'd0, 32'd0);
        queue_item(mk_item(ofai_pkg::OP_TEST, 0, 0, 32'd0, 0, 0));

        // random phases over several register settings
        push_cfg(ofai_pkg::ALPHA_RST, ofai_pkg::W0_RST);
        push_random(RAND_LEN, 0, 0);
        push_cfg($urandom, $urandom);
        push_random(RAND_LEN, 88, 0);
        push_cfg(32'hFFFF_FFFF, 32'd0);
        push_random(RAND_LEN, 0, 88);
        push_cfg($urandom, $urandom);
        push_random(RAND_LEN, 19, 19);

        // fill the run past capacity with a long receiver hold at its start
        push_cfg(32'd0, 32'd0);
        queue_item(mk_item(ofai_pkg::OP_RESTART, 0, 0, 0, 0, 0));
        for (int k = 0; k < TESTS_MAX + 4; k++) begin
            t = mk_item(ofai_pkg::OP_TEST, 10'($urandom), $urandom, $urandom | 32'd1, 0, 0);
            t.hold = (k == 0);
            queue_item(t);
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_q.size() != 0 || i_in_valid || i_cfg_valid || level_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("tb_online_fdr_alpha_investing_top OK");
        else
            $display("tb_online_fdr_alpha_investing_top NOT OK");
        $finish;
    end

    // driver
    t_txn cur_item;
    always @(posedge i_clk) begin
        bit       go;
        t_txn     t;
        t_verdict v;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_cfg_valid <= 1'b0;
            i_op <= ofai_pkg::OP_WRITE;
            i_gamma_index <= '0;
            i_gamma_value <= '0;
            i_p_value <= '0;
            i_cfg_index <= ofai_pkg::CFG_ALPHA;
            i_cfg_data <= '0;
            hold_req <= 1'b0;
        end else begin
            go = 0;
            if (i_in_valid && o_in_ready) begin
                v = level_predict(cur_item);
                level_expect_q.insert(level_expect_q.size(), v);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ofai_pkg::CFG_ALPHA) alpha_reg = i_cfg_data;
                else if (i_cfg_index == ofai_pkg::CFG_W0) wealth_reg = i_cfg_data;
            end
            if (!(i_in_valid && !o_in_ready) && !(i_cfg_valid && !o_cfg_ready)) begin
                if (pending_q.size() != 0) begin
                    if (pending_q[0].is_cfg)
                        go = (level_expect_q.size() == 0) && !o_out_valid;
                    else
                        go = ($urandom_range(99) >= pending_q[0].send_pct);
                end
                if (go) begin
                    t = pending_q.pop_front();
                    cur_item = t;
                    recv_pct <= t.recv_pct;
                    hold_req <= t.hold;
                    i_in_valid <= !t.is_cfg;
                    i_cfg_valid <= t.is_cfg;
                    i_op <= t.op;
                    i_gamma_index <= t.gidx;
                    i_gamma_value <= t.gval;
                    i_p_value <= t.pval;
                    i_cfg_index <= t.cidx;
                    i_cfg_data <= t.cdata;
                end else begin
                    i_in_valid <= 1'b0;
                    i_cfg_valid <= 1'b0;
                    hold_req <= 1'b0;
                end
            end else begin
                hold_req <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_verdict e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (level_expect_q.size() == 0) begin
                    $error("result transfer with nothing expected");
                    fail_cnt++;
                end else begin
                    e = level_expect_q.pop_front();
                    if (o_test_index !== e.test_index) begin
                        $error("test_index exp %0d got %0d", e.test_index, o_test_index);
                        fail_cnt++;
                    end
                    if (o_level !== e.level) begin
                        $error("level exp %h got %h", e.level, o_level);
                        fail_cnt++;
                    end
                    if (o_rejected !== e.rejected) begin
                        $error("rejected exp %0b got %0b", e.rejected, o_rejected);
                        fail_cnt++;
                    end
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status);
                        fail_cnt++;
                    end
                end
            end
            // long hold lets the block back up into its input side
            if (hold_req) begin
                hold_cnt <= HOLD_LEN;
                i_out_ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_pct);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cnt <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cnt <= 0;
        end else if (quiet_cnt >= WDOG_LIMIT) begin
            $display("tb_online_fdr_alpha_investing_top NOT OK");
            $finish;
        end else begin
            quiet_cnt <= quiet_cnt + 1;
        end
    end

endmodule
`default_nettype wire
